@@ hw/rtl/qslerp_pkg.sv @@
`default_nettype none
package qslerp_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int MAX_STEPS    = 24;
    localparam int NUM_LANES    = 2;

    localparam int DATA_W  = 16;
    localparam int BLEND_W = 15;
    localparam int PROD_W  = 2 * DATA_W;
    localparam int DOT_W   = PROD_W + 2;
    localparam int MAG_W   = PROD_W + 1;
    localparam int DQ_W    = 30;
    localparam int SQ_W    = 2 * DQ_W;
    localparam int REM_W   = SQ_W + 1;
    localparam int ROOT_W  = 31;
    localparam int CW      = 34;
    localparam int ANG_W   = 36;
    localparam int TW_W    = BLEND_W + 2;
    localparam int QUO_W   = 36;
    localparam int WT_W    = QUO_W + 1;
    localparam int WP_W    = WT_W + DATA_W;
    localparam int ACC_W   = WP_W + 1;

    localparam logic [MAG_W-1:0] ONE_D     = MAG_W'(1) << (2 * FRAC_BITS);
    localparam logic [MAG_W-1:0] THRESH    = MAG_W'((64'd1 << (2 * FRAC_BITS)) / 1000);
    localparam logic [MAG_W-1:0] LIN_LIMIT = ONE_D - THRESH;

    localparam logic signed [TW_W-1:0] ONE_F = TW_W'(1) <<< FRAC_BITS;

    localparam logic signed [CW-1:0]    Q30_GAIN    = 34'sd652032874;
    localparam logic signed [ANG_W-1:0] Q30_PI      = 36'sd3373259426;
    localparam logic signed [ANG_W-1:0] Q30_HALF_PI = 36'sd1686629713;
    localparam logic signed [ANG_W-1:0] Q30_TWO_PI  = 36'sd6746518852;
    localparam logic signed [ACC_W-1:0] ROUND_HALF  = ACC_W'(1) <<< 29;

    typedef logic signed [DATA_W-1:0] comp_t;

    typedef struct packed {
        comp_t [3:0]        a;
        comp_t [3:0]        b;
        logic [BLEND_W-1:0] blend;
        logic               neg;
        logic               linear;
    } side_t;

    typedef struct packed {
        logic [DQ_W-1:0] dq;
        side_t           base;
    } sq_side_t;

    typedef struct packed {
        logic [ROOT_W-1:0] s;
        side_t             base;
    } ang_side_t;

    function automatic logic signed [CW-1:0] atan_q30(input int idx);
        logic signed [CW-1:0] v;
        case (idx)
            0:  v = 34'sd843314857;
            1:  v = 34'sd497837829;
            2:  v = 34'sd263043837;
            3:  v = 34'sd133525159;
            4:  v = 34'sd67021687;
            5:  v = 34'sd33543516;
            6:  v = 34'sd16775851;
            7:  v = 34'sd8388437;
            8:  v = 34'sd4194283;
            9:  v = 34'sd2097149;
            10: v = 34'sd1048576;
            11: v = 34'sd524288;
            12: v = 34'sd262144;
            13: v = 34'sd131072;
            14: v = 34'sd65536;
            15: v = 34'sd32768;
            16: v = 34'sd16384;
            17: v = 34'sd8192;
            18: v = 34'sd4096;
            19: v = 34'sd2048;
            20: v = 34'sd1024;
            21: v = 34'sd512;
            22: v = 34'sd256;
            23: v = 34'sd128;
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage
`default_nettype wire

@@ hw/rtl/qslerp_sqrt.sv @@
`default_nettype none
module qslerp_sqrt #(
    parameter int SIDE_W = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [qslerp_pkg::REM_W-1:0]   in_value,
    input  wire logic [SIDE_W-1:0]              in_side,
    output logic                                out_valid,
    output logic [qslerp_pkg::ROOT_W-1:0]       out_root,
    output logic [SIDE_W-1:0]                   out_side
);
    import qslerp_pkg::*;

    localparam int RW = 2 * ROOT_W + 1;

    logic [RW-1:0]     rem_reg   [ROOT_W];
    logic [ROOT_W-1:0] root_reg  [ROOT_W];
    logic              valid_reg [ROOT_W];
    logic [SIDE_W-1:0] side_reg  [ROOT_W];

    // One root bit per stage, most significant first.
    for (genvar j = 0; j < ROOT_W; j++) begin : g_stage
        localparam int K = ROOT_W - 1 - j;
        logic [RW-1:0]     rem_in;
        logic [RW-1:0]     trial;
        logic [RW-1:0]     rem_next;
        logic [ROOT_W-1:0] root_in;
        logic [ROOT_W-1:0] root_next;
        logic              v_in;
        logic [SIDE_W-1:0] side_in;

        if (j == 0) begin : g_first
            assign rem_in  = RW'(in_value);
            assign root_in = '0;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            assign rem_in  = rem_reg[j-1];
            assign root_in = root_reg[j-1];
            assign v_in    = valid_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        assign trial = (RW'(root_in) << (K + 1)) + (RW'(1) << (2 * K));

        always_comb
        begin
            if (rem_in >= trial)
            begin
                rem_next  = rem_in - trial;
                root_next = root_in | (ROOT_W'(1) << K);
            end
            else
            begin
                rem_next  = rem_in;
                root_next = root_in;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[j]  <= rem_next;
                root_reg[j] <= root_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[ROOT_W-1];
    assign out_root  = root_reg[ROOT_W-1];
    assign out_side  = side_reg[ROOT_W-1];

endmodule
`default_nettype wire

@@ hw/rtl/qslerp_vec.sv @@
`default_nettype none
module qslerp_vec #(
    parameter int STEPS  = qslerp_pkg::CORDIC_STEPS,
    parameter int SIDE_W = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic [qslerp_pkg::DQ_W-1:0]    in_x,
    input  wire logic [qslerp_pkg::ROOT_W-1:0]  in_y,
    input  wire logic [SIDE_W-1:0]              in_side,
    output logic                                out_valid,
    output logic signed [qslerp_pkg::CW-1:0]    out_angle,
    output logic [SIDE_W-1:0]                   out_side
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] x_reg     [STEPS];
    logic signed [CW-1:0] y_reg     [STEPS];
    logic signed [CW-1:0] z_reg     [STEPS];
    logic                 valid_reg [STEPS];
    logic [SIDE_W-1:0]    side_reg  [STEPS];

    // Drive y toward zero, accumulate the angle.
    for (genvar j = 0; j < STEPS; j++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = atan_q30(j);
        logic signed [CW-1:0] x_in;
        logic signed [CW-1:0] y_in;
        logic signed [CW-1:0] z_in;
        logic signed [CW-1:0] x_next;
        logic signed [CW-1:0] y_next;
        logic signed [CW-1:0] z_next;
        logic                 v_in;
        logic [SIDE_W-1:0]    side_in;

        if (j == 0) begin : g_first
            assign x_in    = $signed(CW'(in_x));
            assign y_in    = $signed(CW'(in_y));
            assign z_in    = '0;
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            assign x_in    = x_reg[j-1];
            assign y_in    = y_reg[j-1];
            assign z_in    = z_reg[j-1];
            assign v_in    = valid_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb
        begin
            if (y_in > 0)
            begin
                x_next = x_in + (y_in >>> j);
                y_next = y_in - (x_in >>> j);
                z_next = z_in + ATAN;
            end
            else
            begin
                x_next = x_in - (y_in >>> j);
                y_next = y_in + (x_in >>> j);
                z_next = z_in - ATAN;
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                x_reg[j]    <= x_next;
                y_reg[j]    <= y_next;
                z_reg[j]    <= z_next;
                side_reg[j] <= side_in;
            end
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_angle = z_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

@@ hw/rtl/qslerp_rot.sv @@
`default_nettype none
module qslerp_rot #(
    parameter int STEPS  = qslerp_pkg::CORDIC_STEPS,
    parameter int SIDE_W = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [qslerp_pkg::CW-1:0] in_angle [qslerp_pkg::NUM_LANES],
    input  wire logic [SIDE_W-1:0]              in_side,
    output logic                                out_valid,
    output logic signed [qslerp_pkg::CW-1:0]    out_sin [qslerp_pkg::NUM_LANES],
    output logic [SIDE_W-1:0]                   out_side
);
    import qslerp_pkg::*;

    logic signed [CW-1:0] x_reg     [STEPS][NUM_LANES];
    logic signed [CW-1:0] y_reg     [STEPS][NUM_LANES];
    logic signed [CW-1:0] z_reg     [STEPS][NUM_LANES];
    logic                 valid_reg [STEPS];
    logic [SIDE_W-1:0]    side_reg  [STEPS];

    // Rotate from the gain-compensated unit vector; both lanes in lockstep.
    for (genvar j = 0; j < STEPS; j++) begin : g_stage
        localparam logic signed [CW-1:0] ATAN = atan_q30(j);
        logic signed [CW-1:0] x_in   [NUM_LANES];
        logic signed [CW-1:0] y_in   [NUM_LANES];
        logic signed [CW-1:0] z_in   [NUM_LANES];
        logic signed [CW-1:0] x_next [NUM_LANES];
        logic signed [CW-1:0] y_next [NUM_LANES];
        logic signed [CW-1:0] z_next [NUM_LANES];
        logic                 v_in;
        logic [SIDE_W-1:0]    side_in;

        if (j == 0) begin : g_first
            always_comb
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    x_in[l] = Q30_GAIN;
                    y_in[l] = '0;
                    z_in[l] = in_angle[l];
                end
            end
            assign v_in    = in_valid;
            assign side_in = in_side;
        end else begin : g_next
            always_comb
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    x_in[l] = x_reg[j-1][l];
                    y_in[l] = y_reg[j-1][l];
                    z_in[l] = z_reg[j-1][l];
                end
            end
            assign v_in    = valid_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if (z_in[l] >= 0)
                begin
                    x_next[l] = x_in[l] - (y_in[l] >>> j);
                    y_next[l] = y_in[l] + (x_in[l] >>> j);
                    z_next[l] = z_in[l] - ATAN;
                end
                else
                begin
                    x_next[l] = x_in[l] + (y_in[l] >>> j);
                    y_next[l] = y_in[l] - (x_in[l] >>> j);
                    z_next[l] = z_in[l] + ATAN;
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    x_reg[j][l] <= x_next[l];
                    y_reg[j][l] <= y_next[l];
                    z_reg[j][l] <= z_next[l];
                end
                side_reg[j] <= side_in;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            out_sin[l] = y_reg[STEPS-1][l];
        end
    end

    assign out_valid = valid_reg[STEPS-1];
    assign out_side  = side_reg[STEPS-1];

endmodule
`default_nettype wire

@@ hw/rtl/qslerp_div.sv @@
`default_nettype none
module qslerp_div #(
    parameter int SIDE_W = 1
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           en,
    input  wire logic                           in_valid,
    input  wire logic signed [qslerp_pkg::CW-1:0] in_num [qslerp_pkg::NUM_LANES],
    input  wire logic [qslerp_pkg::ROOT_W-1:0]  in_div,
    input  wire logic [SIDE_W-1:0]              in_side,
    output logic                                out_valid,
    output logic [qslerp_pkg::QUO_W-1:0]        out_quo [qslerp_pkg::NUM_LANES],
    output logic                                out_neg [qslerp_pkg::NUM_LANES],
    output logic [SIDE_W-1:0]                   out_side
);
    import qslerp_pkg::*;

    logic [CW-1:0]     mag_pre_reg [NUM_LANES];
    logic              neg_pre_reg [NUM_LANES];
    logic [ROOT_W-1:0] div_pre_reg;
    logic              v_pre_reg;
    logic [SIDE_W-1:0] side_pre_reg;

    logic [ROOT_W-1:0] r_reg    [QUO_W][NUM_LANES];
    logic [QUO_W-1:0]  low_reg  [QUO_W][NUM_LANES];
    logic [QUO_W-1:0]  q_reg    [QUO_W][NUM_LANES];
    logic              neg_reg  [QUO_W][NUM_LANES];
    logic [ROOT_W-1:0] div_reg  [QUO_W];
    logic              valid_reg[QUO_W];
    logic [SIDE_W-1:0] side_reg [QUO_W];

    // Split off the sign; the quotient truncates toward zero.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_pre_reg <= 1'b0;
        end
        else if (en)
        begin
            v_pre_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                neg_pre_reg[l] <= in_num[l] < 0;
                mag_pre_reg[l] <= (in_num[l] < 0) ? CW'(-in_num[l]) : CW'(in_num[l]);
            end
            div_pre_reg  <= in_div;
            side_pre_reg <= in_side;
        end
    end

    // Restoring division, one quotient bit per stage.
    for (genvar j = 0; j < QUO_W; j++) begin : g_stage
        localparam int K = QUO_W - 1 - j;
        logic [ROOT_W-1:0] r_in    [NUM_LANES];
        logic [QUO_W-1:0]  low_in  [NUM_LANES];
        logic [QUO_W-1:0]  q_in    [NUM_LANES];
        logic              neg_in  [NUM_LANES];
        logic [ROOT_W-1:0] r_next  [NUM_LANES];
        logic [QUO_W-1:0]  q_next  [NUM_LANES];
        logic [ROOT_W-1:0] div_in;
        logic              v_in;
        logic [SIDE_W-1:0] side_in;

        if (j == 0) begin : g_first
            always_comb
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    r_in[l]   = ROOT_W'({mag_pre_reg[l], 30'b0} >> QUO_W);
                    low_in[l] = QUO_W'({mag_pre_reg[l], 30'b0});
                    q_in[l]   = '0;
                    neg_in[l] = neg_pre_reg[l];
                end
            end
            assign div_in  = div_pre_reg;
            assign v_in    = v_pre_reg;
            assign side_in = side_pre_reg;
        end else begin : g_next
            always_comb
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    r_in[l]   = r_reg[j-1][l];
                    low_in[l] = low_reg[j-1][l];
                    q_in[l]   = q_reg[j-1][l];
                    neg_in[l] = neg_reg[j-1][l];
                end
            end
            assign div_in  = div_reg[j-1];
            assign v_in    = valid_reg[j-1];
            assign side_in = side_reg[j-1];
        end

        always_comb
        begin
            for (int l = 0; l < NUM_LANES; l++)
            begin
                if ({r_in[l], low_in[l][K]} >= {1'b0, div_in})
                begin
                    r_next[l] = ROOT_W'({r_in[l], low_in[l][K]} - {1'b0, div_in});
                    q_next[l] = q_in[l] | (QUO_W'(1) << K);
                end
                else
                begin
                    r_next[l] = ROOT_W'({r_in[l], low_in[l][K]});
                    q_next[l] = q_in[l];
                end
            end
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[j] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[j] <= v_in;
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                for (int l = 0; l < NUM_LANES; l++)
                begin
                    r_reg[j][l]   <= r_next[l];
                    low_reg[j][l] <= low_in[l];
                    q_reg[j][l]   <= q_next[l];
                    neg_reg[j][l] <= neg_in[l];
                end
                div_reg[j]  <= div_in;
                side_reg[j] <= side_in;
            end
        end
    end

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            out_quo[l] = q_reg[QUO_W-1][l];
            out_neg[l] = neg_reg[QUO_W-1][l];
        end
    end

    assign out_valid = valid_reg[QUO_W-1];
    assign out_side  = side_reg[QUO_W-1];

endmodule
`default_nettype wire

@@ hw/rtl/quaternion_slerp_core.sv @@
`default_nettype none
// Channel   Direction  Width  Contents
// s_*       in         144    tdata: a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, blend, pad
// m_*       out        64     tdata: r_x, r_y, r_z, r_w; tuser: used_linear
//
// The pipeline takes one transfer per cycle unless it is stalled.
// The depth comes from the square root (one bit a stage), the two CORDIC chains
// (one step a stage) and the two-lane divider (one quotient bit a stage).
// Reset clears only the valid bits; nothing else is kept between items.
// The whole pipeline holds while the output register is full and not taken,
// so a stall neither drops nor repeats a transfer.
module quaternion_slerp_core #(
    parameter int CORDIC_STEPS = qslerp_pkg::CORDIC_STEPS
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w (16 each), blend (15), one zero bit
    input  wire logic [143:0] s_tdata,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    // r_x, r_y, r_z, r_w (16 each)
    output logic [63:0]      m_tdata,
    // used_linear
    output logic [0:0]       m_tuser
);
    import qslerp_pkg::*;

    logic en;

    // Input split.
    side_t in_side;
    always_comb
    begin
        in_side = '0;
        for (int i = 0; i < 4; i++)
        begin
            in_side.a[i] = s_tdata[DATA_W*i +: DATA_W];
            in_side.b[i] = s_tdata[DATA_W*(i+4) +: DATA_W];
        end
        in_side.blend = s_tdata[8*DATA_W +: BLEND_W];
    end

    // Stage 1: four component products.
    logic signed [PROD_W-1:0] prod_reg [4];
    side_t                    s1_side_reg;
    logic                     v1_reg;

    // Stage 2: dot product, sign fold, near-parallel test, move to Q30.
    logic signed [DOT_W-1:0]  dot_next;
    logic [MAG_W-1:0]         mag_next;
    logic                     lin_next;
    side_t                    s2_side_next;
    logic [DQ_W-1:0]          dq_reg;
    side_t                    s2_side_reg;
    logic                     v2_reg;

    // Stage 3 and 4: 1 - d^2 in Q60.
    logic [SQ_W-1:0]          sq_reg;
    logic [DQ_W-1:0]          dq3_reg;
    side_t                    s3_side_reg;
    logic                     v3_reg;
    logic [REM_W-1:0]         rem_reg;
    sq_side_t                 s4_side_reg;
    logic                     v4_reg;

    logic                     sq_valid;
    logic [ROOT_W-1:0]        sq_root;
    sq_side_t                 sq_side;
    logic [ROOT_W-1:0]        s_fix;
    ang_side_t                vec_side_in;

    logic                     vec_valid;
    logic signed [CW-1:0]     theta;
    ang_side_t                vec_side;

    // Stage 6 to 8: scale the angle, wrap, fold into the CORDIC range.
    logic signed [TW_W-1:0]   tw_a;
    logic signed [TW_W-1:0]   tw_b;
    logic signed [PROD_W+TW_W-1:0] ang_prod_reg [NUM_LANES];
    ang_side_t                s6_side_reg;
    logic                     v6_reg;
    logic signed [ANG_W-1:0]  wrap_next [NUM_LANES];
    logic signed [ANG_W-1:0]  wrap_reg  [NUM_LANES];
    ang_side_t                s7_side_reg;
    logic                     v7_reg;
    logic signed [ANG_W-1:0]  fold_next [NUM_LANES];
    logic signed [CW-1:0]     fold_reg  [NUM_LANES];
    ang_side_t                s8_side_reg;
    logic                     v8_reg;

    logic                     rot_valid;
    logic signed [CW-1:0]     rot_sin [NUM_LANES];
    ang_side_t                rot_side;

    logic                     div_valid;
    logic [QUO_W-1:0]         div_quo [NUM_LANES];
    logic                     div_neg [NUM_LANES];
    side_t                    div_side;

    // Stage 9 to 12: weights, products, sum, round and saturate.
    logic signed [WT_W-1:0]   wa_next;
    logic signed [WT_W-1:0]   wb_next;
    logic signed [WT_W-1:0]   wa_reg;
    logic signed [WT_W-1:0]   wb_reg;
    side_t                    s9_side_reg;
    logic                     v9_reg;
    logic signed [WP_W-1:0]   pa_reg [4];
    logic signed [WP_W-1:0]   pb_reg [4];
    logic                     lin10_reg;
    logic                     v10_reg;
    logic signed [ACC_W-1:0]  acc_reg [4];
    logic                     lin11_reg;
    logic                     v11_reg;
    logic [DATA_W-1:0]        res_reg [4];
    logic                     lin_out_reg;
    logic                     v_out_reg;

    // Advance everything unless a finished result is waiting.
    assign en       = !v_out_reg || m_tready;
    assign s_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            v3_reg    <= 1'b0;
            v4_reg    <= 1'b0;
            v6_reg    <= 1'b0;
            v7_reg    <= 1'b0;
            v8_reg    <= 1'b0;
            v9_reg    <= 1'b0;
            v10_reg   <= 1'b0;
            v11_reg   <= 1'b0;
            v_out_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg    <= s_tvalid;
            v2_reg    <= v1_reg;
            v3_reg    <= v2_reg;
            v4_reg    <= v3_reg;
            v6_reg    <= vec_valid;
            v7_reg    <= v6_reg;
            v8_reg    <= v7_reg;
            v9_reg    <= div_valid;
            v10_reg   <= v9_reg;
            v11_reg   <= v10_reg;
            v_out_reg <= v11_reg;
        end
    end

    always_comb
    begin
        dot_next = DOT_W'(prod_reg[0]) + DOT_W'(prod_reg[1])
                 + DOT_W'(prod_reg[2]) + DOT_W'(prod_reg[3]);
        mag_next = (dot_next < 0) ? MAG_W'(-dot_next) : MAG_W'(dot_next);
        lin_next = mag_next >= LIN_LIMIT;

        s2_side_next        = s1_side_reg;
        s2_side_next.neg    = dot_next < 0;
        s2_side_next.linear = lin_next;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int i = 0; i < 4; i++)
            begin
                prod_reg[i] <= in_side.a[i] * in_side.b[i];
            end
            s1_side_reg <= in_side;

            // Linear items send zero through the trig path to keep it bounded.
            dq_reg <= lin_next ? '0 : DQ_W'(mag_next << (30 - 2 * FRAC_BITS));
            s2_side_reg <= s2_side_next;

            sq_reg      <= dq_reg * dq_reg;
            dq3_reg     <= dq_reg;
            s3_side_reg <= s2_side_reg;

            rem_reg     <= (REM_W'(1) << 60) - REM_W'(sq_reg);
            s4_side_reg <= '{dq: dq3_reg, base: s3_side_reg};
        end
    end

    qslerp_sqrt #(
        .SIDE_W ($bits(sq_side_t))
    ) u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v4_reg),
        .in_value  (rem_reg),
        .in_side   (s4_side_reg),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_side  (sq_side)
    );

    // sin(theta) is the root itself; keep it nonzero for the divide.
    assign s_fix = (sq_root == '0) ? ROOT_W'(1) : sq_root;
    always_comb
    begin
        vec_side_in.s    = s_fix;
        vec_side_in.base = sq_side.base;
    end

    qslerp_vec #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(ang_side_t))
    ) u_vec (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (sq_valid),
        .in_x      (sq_side.dq),
        .in_y      (s_fix),
        .in_side   (vec_side_in),
        .out_valid (vec_valid),
        .out_angle (theta),
        .out_side  (vec_side)
    );

    assign tw_a = ONE_F - $signed(TW_W'(vec_side.base.blend));
    assign tw_b = $signed(TW_W'(vec_side.base.blend));

    always_comb
    begin
        for (int l = 0; l < NUM_LANES; l++)
        begin
            wrap_next[l] = ANG_W'(ang_prod_reg[l] >>> FRAC_BITS);
            if (wrap_next[l] > Q30_PI)
            begin
                wrap_next[l] = wrap_next[l] - Q30_TWO_PI;
            end
            if (wrap_next[l] <= -Q30_PI)
            begin
                wrap_next[l] = wrap_next[l] + Q30_TWO_PI;
            end

            fold_next[l] = wrap_reg[l];
            if (fold_next[l] > Q30_HALF_PI)
            begin
                fold_next[l] = Q30_PI - fold_next[l];
            end
            if (fold_next[l] < -Q30_HALF_PI)
            begin
                fold_next[l] = -Q30_PI - fold_next[l];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ang_prod_reg[0] <= $signed(theta[PROD_W-1:0]) * tw_a;
            ang_prod_reg[1] <= $signed(theta[PROD_W-1:0]) * tw_b;
            s6_side_reg     <= vec_side;
            for (int l = 0; l < NUM_LANES; l++)
            begin
                wrap_reg[l] <= wrap_next[l];
                fold_reg[l] <= CW'(fold_next[l]);
            end
            s7_side_reg <= s6_side_reg;
            s8_side_reg <= s7_side_reg;
        end
    end

    qslerp_rot #(
        .STEPS  (CORDIC_STEPS),
        .SIDE_W ($bits(ang_side_t))
    ) u_rot (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v8_reg),
        .in_angle  (fold_reg),
        .in_side   (s8_side_reg),
        .out_valid (rot_valid),
        .out_sin   (rot_sin),
        .out_side  (rot_side)
    );

    qslerp_div #(
        .SIDE_W ($bits(side_t))
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (rot_valid),
        .in_num    (rot_sin),
        .in_div    (rot_side.s),
        .in_side   (rot_side.base),
        .out_valid (div_valid),
        .out_quo   (div_quo),
        .out_neg   (div_neg),
        .out_side  (div_side)
    );

    // Pick linear or spherical weights; a negative dot flips the weight on b.
    always_comb
    begin
        if (div_side.linear)
        begin
            wa_next = WT_W'(ONE_F - $signed(TW_W'(div_side.blend))) <<< (30 - FRAC_BITS);
            wb_next = div_side.neg
                    ? -(WT_W'(div_side.blend) <<< (30 - FRAC_BITS))
                    :  (WT_W'(div_side.blend) <<< (30 - FRAC_BITS));
        end
        else
        begin
            wa_next = div_neg[0] ? -$signed(WT_W'(div_quo[0])) : $signed(WT_W'(div_quo[0]));
            wb_next = (div_neg[1] ^ div_side.neg)
                    ? -$signed(WT_W'(div_quo[1])) : $signed(WT_W'(div_quo[1]));
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            wa_reg      <= wa_next;
            wb_reg      <= wb_next;
            s9_side_reg <= div_side;

            for (int i = 0; i < 4; i++)
            begin
                pa_reg[i]  <= wa_reg * s9_side_reg.a[i];
                pb_reg[i]  <= wb_reg * s9_side_reg.b[i];
                acc_reg[i] <= ACC_W'(pa_reg[i]) + ACC_W'(pb_reg[i]) + ROUND_HALF;
                if ($signed(acc_reg[i][ACC_W-1:30]) > 32767)
                begin
                    res_reg[i] <= 16'h7fff;
                end
                else if ($signed(acc_reg[i][ACC_W-1:30]) < -32768)
                begin
                    res_reg[i] <= 16'h8000;
                end
                else
                begin
                    res_reg[i] <= acc_reg[i][30 +: DATA_W];
                end
            end
            lin10_reg   <= s9_side_reg.linear;
            lin11_reg   <= lin10_reg;
            lin_out_reg <= lin11_reg;
        end
    end

    assign m_tvalid = v_out_reg;
    assign m_tdata  = {res_reg[3], res_reg[2], res_reg[1], res_reg[0]};
    assign m_tuser  = lin_out_reg;

endmodule
`default_nettype wire
